>>> src/fas_pkg.sv
package fas_pkg;

  localparam logic [31:0] ExpMask  = 32'h7f800000;
  localparam logic [31:0] FracMask = 32'h007fffff;
  localparam logic [31:0] SignBit  = 32'h80000000;
  localparam logic [31:0] PosInf   = 32'h7f800000;
  localparam logic [31:0] NegInf   = 32'hff800000;
  localparam logic [31:0] QnanNeg  = 32'hffc00000;
  localparam logic [23:0] Hidden   = 24'h800000;

  typedef enum logic {
    OpAdd = 1'b0,
    OpSub = 1'b1
  } op_e;

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
  } operands_t;

endpackage

>>> src/fas_core.sv
module fas_core (
  input  fas_pkg::operands_t ops_i,
  output logic [31:0]        sum_o
);
  import fas_pkg::*;

  logic [31:0] a, b, x, y;
  logic [7:0]  ea, eb, ex, ey, diff;
  logic [23:0] mx, my;
  logic [48:0] big, mag;
  logic        sig;
  logic [5:0]  msb;
  logic signed [9:0] se;
  logic [48:0] sm_full;
  logic [24:0] sm;
  logic [48:0] rest, half, rmask;
  logic [5:0]  k;
  logic [24:0] subn;
  logic        a_nan, b_nan;

  always_comb begin
    a = ops_i.a;
    b = ops_i.b;
    a_nan = ((a & ExpMask) == ExpMask) && ((a & FracMask) != 32'd0);
    b_nan = ((b & ExpMask) == ExpMask) && ((b & FracMask) != 32'd0);
    ea = a[30:23];
    eb = b[30:23];
    if (eb > ea) begin
      x = b; y = a; ex = eb; ey = ea;
    end else begin
      x = a; y = b; ex = ea; ey = eb;
    end
    mx = (ex == 8'd0) ? {1'b0, x[22:0]} : {1'b1, x[22:0]};
    my = (ey == 8'd0) ? {1'b0, y[22:0]} : {1'b1, y[22:0]};
    if (ex == 8'd0) ex = 8'd1;
    if (ey == 8'd0) ey = 8'd1;
    diff = ex - ey;
    big = {25'd0, mx} << diff[4:0];
    if (x[31] == y[31]) begin
      mag = big + {25'd0, my}; sig = x[31];
    end else if (big >= {25'd0, my}) begin
      mag = big - {25'd0, my}; sig = x[31];
    end else begin
      mag = {25'd0, my} - big; sig = y[31];
    end
    msb = 6'd0;
    for (int i = 0; i < 49; i++) begin
      if (mag[i]) msb = 6'(i);
    end
    se = $signed({2'b00, ey}) + $signed({4'd0, msb}) - 10'sd23;
    if (msb > 6'd23) begin
      k = msb - 6'd23;
      sm_full = mag >> k;
    end else begin
      k = 6'd0;
      sm_full = mag << (6'd23 - msb);
    end
    sm = sm_full[24:0];
    rmask = (49'd1 << k) - 49'd1;
    rest = mag & rmask;
    half = (k == 6'd0) ? 49'd0 : (49'd1 << (k - 6'd1));
    subn = sm >> (10'sd1 - se);
    if (k != 6'd0 && (rest > half || (rest == half && sm[0]))) sm = sm + 25'd1;
    if (sm[24]) begin
      sm = sm >> 1;
      se = se + 10'sd1;
    end
    if (a_nan) sum_o = a;
    else if (b_nan) sum_o = b;
    else if (a == 32'd0 && b == SignBit) sum_o = 32'd0;
    else if ((a & ~SignBit) == 32'd0) sum_o = b;
    else if ((b & ~SignBit) == 32'd0) sum_o = a;
    else if ((a == PosInf && b == NegInf) || (a == NegInf && b == PosInf)) sum_o = QnanNeg;
    else if ((a & ~SignBit) == PosInf) sum_o = a;
    else if ((b & ~SignBit) == PosInf) sum_o = b;
    else if (diff > 8'd24) sum_o = x;
    else if (mag == 49'd0) sum_o = 32'd0;
    else if ($signed({2'b00, ey}) + $signed({4'd0, msb}) - 10'sd23 <= 10'sd0)
      sum_o = {sig, 8'd0, subn[22:0]};
    else if ($signed({2'b00, ey}) + $signed({4'd0, msb}) - 10'sd23 >= 10'sd255)
      sum_o = {sig, PosInf[30:0]};
    else
      sum_o = {sig, 31'd0} + {1'b0, se[7:0], 23'd0} + {9'd0, sm[22:0]};
  end

endmodule

>>> src/float32_add_sub.sv
// Single-precision add/subtract on a stream: one item per cycle unless the output
// stalls, one result per item. A result passes the input register, then the result
// register, and is held while the output is stalled; input is held off only when
// both registers are full and the output is stalled. tuser selects subtract, which
// inverts operand_b's sign. NaNs pass through; round-half-even, subnormals truncate.
module float32_add_sub (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,  // operand_a [31:0], operand_b [63:32]
  input  logic        s_axis_tuser,  // op
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata   // sum_bits
);
  import fas_pkg::*;

  logic               in_vld_q, out_vld_q;
  operands_t          ops_q, ops_d;
  logic [31:0]        res_q, res_c;
  logic               adv;

  assign adv = !out_vld_q || m_axis_tready;
  assign s_axis_tready = !in_vld_q || adv;

  always_comb begin
    ops_d.a = s_axis_tdata[31:0];
    ops_d.b = s_axis_tdata[63:32];
    if (op_e'(s_axis_tuser) == OpSub) ops_d.b = ops_d.b ^ SignBit;
  end

  fas_core u_core (.ops_i(ops_q), .sum_o(res_c));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (adv) out_vld_q <= in_vld_q;
      if (s_axis_tready) in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) ops_q <= ops_d;
    if (adv && in_vld_q) res_q <= res_c;
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = res_q;

endmodule

>>> src/fas_checker.sv
module fas_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata
);
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");
  a_lat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && m_axis_tready |=> ##1 m_axis_tvalid)
    else $error("result missing two cycles after item");
  a_rdy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output");
endmodule

bind float32_add_sub fas_checker u_fas_checker (.*);

>>> tb/float32_add_sub_tb.sv
module float32_add_sub_tb;
  import fas_pkg::*;

  class sum_scoreboard;
    logic [31:0] pending_sums[$];
    int errors = 0;

    function automatic logic [5:0] top_bit(logic [63:0] v);
      logic [5:0] p;
      p = '0;
      for (int i = 0; i < 64; i++) if (v[i]) p = i[5:0];
      return p;
    endfunction

    function automatic logic [31:0] predict_sum(op_e op, logic [31:0] a, logic [31:0] b);
      logic [31:0] ea, eb, t, gap;
      logic [63:0] ma, mb, big, mag, sm, rest, half;
      logic sa, sb, sgn;
      logic [5:0] msb;
      int se, k;
      if (op == OpSub) b = b ^ SignBit;
      if ((a & ExpMask) == ExpMask && (a & FracMask) != 0) return a;
      if ((b & ExpMask) == ExpMask && (b & FracMask) != 0) return b;
      if (a == 0 && b == SignBit) return 32'h0;
      if ((a & ~SignBit) == 0) return b;
      if ((b & ~SignBit) == 0) return a;
      if ((a == PosInf && b == NegInf) || (a == NegInf && b == PosInf)) return QnanNeg;
      if ((a & ~SignBit) == PosInf) return a;
      if ((b & ~SignBit) == PosInf) return b;
      ea = {24'h0, a[30:23]};
      eb = {24'h0, b[30:23]};
      if (eb > ea) begin
        t = ea; ea = eb; eb = t;
        t = a; a = b; b = t;
      end
      if (ea == 0) begin
        ea = 1; ma = {41'h0, a[22:0]};
      end else begin
        ma = {40'h0, 1'b1, a[22:0]};
      end
      if (eb == 0) begin
        eb = 1; mb = {41'h0, b[22:0]};
      end else begin
        mb = {40'h0, 1'b1, b[22:0]};
      end
      gap = ea - eb;
      if (gap > 24) return a;
      big = ma << gap;
      sa = a[31];
      sb = b[31];
      if (sa == sb) begin
        mag = big + mb; sgn = sa;
      end else if (big >= mb) begin
        mag = big - mb; sgn = sa;
      end else begin
        mag = mb - big; sgn = sb;
      end
      if (mag == 0) return 32'h0;
      msb = top_bit(mag);
      se = int'(eb) + int'(msb) - 23;
      sm = (msb > 23) ? (mag >> (msb - 23)) : (mag << (23 - msb));
      if (se <= 0) return {sgn, 31'h0} | 32'(sm >> (1 - se));
      if (se >= 255) return {sgn, 31'h0} | PosInf;
      if (msb > 23) begin
        k = msb - 23;
        rest = mag & ((64'h1 << k) - 1);
        half = 64'h1 << (k - 1);
        if (rest > half || (rest == half && sm[0])) sm = sm + 1;
      end
      if ((sm >> 23) > 1) begin
        sm = sm >> 1;
        se++;
      end
      return {sgn, 31'h0} + (32'(se) << 23) + (32'(sm) & FracMask);
    endfunction

    function void note_operands(op_e op, logic [31:0] a, logic [31:0] b);
      pending_sums.push_back(predict_sum(op, a, b));
    endfunction

    function void check_sum(logic [31:0] got);
      logic [31:0] want;
      if (pending_sums.size() == 0) begin
        $error("sum_bits: unexpected item, actual %h", got);
        errors++;
        return;
      end
      want = pending_sums.pop_front();
      if (got !== want) begin
        $error("sum_bits: expected %h, actual %h", want, got);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata;
  logic        s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;

  sum_scoreboard board;
  int idle_cycles = 0;
  bit stimulus_done = 1'b0;

  float32_add_sub DUT (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [31:0] random_float();
    logic [31:0] w;
    w = $urandom;
    case ($urandom_range(0, 9))
      0: w[30:23] = 8'h00;
      1: w[30:23] = 8'hff;
      2: w[30:23] = 8'hfe;
      3: w[30:0] = 31'h0;
      4: w[22:0] = 23'($urandom_range(0, 3));
      default: ;
    endcase
    return w;
  endfunction

  task automatic send_operands(op_e op, logic [31:0] a, logic [31:0] b);
    int gap;
    gap = $urandom_range(0, 4);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {b, a};
    s_axis_tuser <= op;
    do @(posedge clk_i); while (!s_axis_tready);
    board.note_operands(op, a, b);
  endtask

  task automatic send_pair(logic [31:0] a, logic [31:0] b);
    send_operands(OpAdd, a, b);
    send_operands(OpSub, a, b);
  endtask

  initial begin
    int n;
    board = new();
    rst_ni = 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata <= '0;
    s_axis_tuser <= 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send_pair(32'h7fc00001, 32'h3f800000);
    send_pair(32'h3f800000, 32'hff800001);
    send_pair(32'h00000000, 32'h80000000);
    send_pair(32'h00000000, 32'h40490fdb);
    send_pair(32'hc0000000, 32'h80000000);
    send_pair(PosInf, PosInf);
    send_pair(PosInf, 32'h3f800000);
    send_pair(32'h7f7fffff, NegInf);
    send_pair(32'h4b800000, 32'h3f800000);
    send_pair(32'h3f800001, 32'h3f800001);
    send_pair(32'h00800000, 32'h00000001);
    send_pair(32'h7f7fffff, 32'h7f7fffff);
    send_pair(32'h4b7fffff, 32'h3f000000);
    send_operands(OpAdd, 32'hffffffff, 32'hffffffff);
    n = 0;
    while (n < 800) begin
      send_operands(op_e'($urandom_range(0, 1)), random_float(), random_float());
      n++;
    end
    s_axis_tvalid <= 1'b0;
    while (board.pending_sums.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    stimulus_done = 1'b1;
  end

  initial begin
    int wait_cycles;
    m_axis_tready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      wait_cycles = $urandom_range(0, 4);
      if ($urandom_range(0, 3) == 0) wait_cycles = 0;
      if (wait_cycles > 0) begin
        m_axis_tready <= 1'b0;
        repeat (wait_cycles) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      board.check_sum(m_axis_tdata);
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    wait (stimulus_done || idle_cycles >= 2000);
    if (stimulus_done && board.errors == 0 && board.pending_sums.size() == 0) begin
      $display("float32_add_sub regression: pass");
    end else begin
      $display("float32_add_sub regression: fail");
    end
    $finish;
  end

endmodule

>>> sim.f
src/fas_pkg.sv
src/fas_core.sv
src/float32_add_sub.sv
src/fas_checker.sv
tb/float32_add_sub_tb.sv
